>>> rtl/core/rgf_pkg.sv
// Shared types and constants of the range glitch filter.
package rgf_pkg;

  localparam int RANGE_W  = 16;
  localparam int LIGHT_W  = 8;
  localparam int SENSOR_W = 1;
  localparam int CAP_W    = 16;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;
  localparam int REG_IDX_W = APB_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_DISTANCE_CAP = '0;
  localparam logic [CAP_W-1:0]     CAP_RESET        = '1;

  localparam logic ACT_RANGE = 1'b0;
  localparam logic ACT_LIGHT = 1'b1;

  localparam logic [1:0] ZERO_SKIP_MAX = 2'd2;

  typedef struct packed {
    logic                action;
    logic [SENSOR_W-1:0] sensor;
    logic                read_ok;
    logic [RANGE_W-1:0]  range_value;
    logic [LIGHT_W-1:0]  light_value;
  } rgf_item_t;

  typedef struct packed {
    logic                push;
    logic [SENSOR_W-1:0] sensor;
    logic [RANGE_W-1:0]  value;
  } rgf_push_t;

endpackage

>>> rtl/core/rgf_ifs.sv
// Valid/ready channel interfaces for the input items and the results.
interface rgf_in_if;
  import rgf_pkg::*;
  logic                valid;
  logic                ready;
  logic                action;
  logic [SENSOR_W-1:0] sensor;
  logic                read_ok;
  logic [RANGE_W-1:0]  range_value;
  logic [LIGHT_W-1:0]  light_value;

  modport source (output valid, action, sensor, read_ok, range_value, light_value,
                  input ready);
  modport sink   (input valid, action, sensor, read_ok, range_value, light_value,
                  output ready);
endinterface

interface rgf_out_if;
  import rgf_pkg::*;
  logic                valid;
  logic                ready;
  logic [SENSOR_W-1:0] sensor_out;
  logic [RANGE_W-1:0]  distance;
  logic [LIGHT_W-1:0]  light_level;

  modport source (output valid, sensor_out, distance, light_level, input ready);
  modport sink   (input valid, sensor_out, distance, light_level, output ready);
endinterface

>>> rtl/core/rgf_ring.sv
// Per-sensor sample rings with running sums and rounded means.
module rgf_ring #(
  parameter int NUM_SENSORS = 2,
  parameter int RING_DEPTH  = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rgf_pkg::rgf_push_t          push_i,
  output logic [rgf_pkg::RANGE_W-1:0] dist_o
);
  import rgf_pkg::*;

  localparam int SW   = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int PW   = $clog2(RING_DEPTH);
  localparam int SUMW = RANGE_W + PW;
  localparam int DIV  = 2 * RING_DEPTH;
  localparam int XW   = SUMW + 2;
  localparam int LW   = $clog2(DIV);
  localparam int MW   = XW + 2;
  localparam int PRW  = XW + MW;
  localparam logic [MW-1:0] MUL =
    MW'(((64'd1 << (XW + LW)) + 64'(DIV) - 64'd1) / 64'(DIV));
  localparam logic [PW-1:0] POS_LAST = PW'(RING_DEPTH - 1);

  logic [RANGE_W-1:0] ring_r [NUM_SENSORS][RING_DEPTH];
  logic [PW-1:0]      pos_r  [NUM_SENSORS];
  logic [SUMW-1:0]    sum_r  [NUM_SENSORS];
  logic [RANGE_W-1:0] dist_r [NUM_SENSORS];

  logic               sens_ok;
  logic [SW-1:0]      idx;
  logic               do_push;
  logic [RANGE_W-1:0] old_val;
  logic [SUMW-1:0]    sum_nxt;
  logic [PW-1:0]      pos_nxt;
  logic [XW-1:0]      x;
  logic [PRW-1:0]     prod;
  logic [RANGE_W-1:0] mean;

  always_comb begin
    sens_ok = (32'(push_i.sensor) < NUM_SENSORS);
    idx     = sens_ok ? SW'(push_i.sensor) : '0;
    do_push = push_i.push && sens_ok;
    old_val = ring_r[idx][pos_r[idx]];
    sum_nxt = SUMW'(({1'b0, sum_r[idx]} + (SUMW+1)'(push_i.value)) - (SUMW+1)'(old_val));
    pos_nxt = (pos_r[idx] == POS_LAST) ? '0 : pos_r[idx] + 1'b1;
    x       = {1'b0, sum_nxt, 1'b0} + XW'(RING_DEPTH);
    prod    = PRW'(x) * PRW'(MUL);
    mean    = RANGE_W'(prod >> (XW + LW));
    if (!sens_ok) begin
      dist_o = '0;
    end else if (do_push) begin
      dist_o = mean;
    end else begin
      dist_o = dist_r[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SENSORS; s++) begin
        for (int e = 0; e < RING_DEPTH; e++) begin
          ring_r[s][e] <= '0;
        end
        pos_r[s]  <= '0;
        sum_r[s]  <= '0;
        dist_r[s] <= '0;
      end
    end else if (do_push) begin
      ring_r[idx][pos_r[idx]] <= push_i.value;
      pos_r[idx]              <= pos_nxt;
      sum_r[idx]              <= sum_nxt;
      dist_r[idx]             <= mean;
    end
  end

endmodule

>>> rtl/core/range_glitch_filter_moving_average.sv
// Range glitch filter with per-sensor moving average and held light level.
//
//   Channel  Direction  Handshake           Contents
//   in_ch    sink       valid/ready         action, sensor, read_ok, range, light
//   out_ch   source     valid/ready         sensor_out, distance, light_level
//   cfg_*    slave      APB, pready tied 1  distance_cap at byte address 0
//
// One transaction per cycle sustained while out_ch.ready stays high.
// Items pass an input register, then one pass of ring update, running-sum
// update, reciprocal multiply and distance cap into the result register.
// Reset (rst_n low, synchronous) clears the rings, sums, zero counter and light.
// A stalled result holds both registers; in_ch.ready drops only then.
module range_glitch_filter_moving_average #(
  parameter int NUM_SENSORS = 2,
  parameter int RING_DEPTH  = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  rgf_in_if.sink                     in_ch,
  rgf_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [rgf_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [rgf_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [rgf_pkg::APB_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import rgf_pkg::*;

  logic               s1_valid_r;
  rgf_item_t          s1_item_r;
  logic               out_valid_r;
  logic [SENSOR_W-1:0] out_sensor_r;
  logic [RANGE_W-1:0] out_dist_r;
  logic [LIGHT_W-1:0] light_r;
  logic [LIGHT_W-1:0] light_nxt;
  logic [1:0]         zero_run_r;
  logic [1:0]         zero_run_nxt;
  logic [CAP_W-1:0]   cap_r;

  logic               out_load;
  logic               s1_fire;
  logic               in_fire;
  logic               sens_ok;
  logic               range_ok;
  logic               skip_zero;
  rgf_push_t          push;
  logic [RANGE_W-1:0] ring_dist;
  logic [RANGE_W-1:0] dist_capped;
  logic               cfg_wr;

  assign out_load    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && out_load;
  assign in_ch.ready = !s1_valid_r || out_load;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    sens_ok   = (32'(s1_item_r.sensor) < NUM_SENSORS);
    range_ok  = s1_fire && (s1_item_r.action == ACT_RANGE) && s1_item_r.read_ok && sens_ok;
    skip_zero = (s1_item_r.range_value == '0) && (zero_run_r <= ZERO_SKIP_MAX);

    push.push   = range_ok && !skip_zero;
    push.sensor = s1_item_r.sensor;
    push.value  = s1_item_r.range_value;

    zero_run_nxt = zero_run_r;
    if (range_ok) begin
      if (s1_item_r.range_value != '0) begin
        zero_run_nxt = '0;
      end else if (skip_zero) begin
        zero_run_nxt = zero_run_r + 2'd1;
      end
    end

    light_nxt = light_r;
    if (s1_fire && (s1_item_r.action == ACT_LIGHT) && s1_item_r.read_ok &&
        (s1_item_r.light_value != '0)) begin
      light_nxt = s1_item_r.light_value;
    end

    dist_capped = (ring_dist > cap_r) ? cap_r : ring_dist;
  end

  rgf_ring #(
    .NUM_SENSORS (NUM_SENSORS),
    .RING_DEPTH  (RING_DEPTH)
  ) u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .dist_o (ring_dist)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      zero_run_r  <= '0;
      light_r     <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      zero_run_r <= zero_run_nxt;
      light_r    <= light_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.action      <= in_ch.action;
      s1_item_r.sensor      <= in_ch.sensor;
      s1_item_r.read_ok     <= in_ch.read_ok;
      s1_item_r.range_value <= in_ch.range_value;
      s1_item_r.light_value <= in_ch.light_value;
    end
    if (s1_fire) begin
      out_sensor_r <= s1_item_r.sensor;
      out_dist_r   <= dist_capped;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.sensor_out  = out_sensor_r;
  assign out_ch.distance    = out_dist_r;
  assign out_ch.light_level = light_r;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[APB_AW-1:2] == REG_DISTANCE_CAP);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr[APB_AW-1:2])
      REG_DISTANCE_CAP: cfg_prdata = APB_DW'(cap_r);
      default:          cfg_prdata = '0;
    endcase
  end

endmodule
